### hdl/ngga_pkg.sv
// shared types, constants and helper functions of the gga sentence parser
package ngga_pkg;

	localparam int DEF_MAX_SENTENCE_BYTES = 81;
	localparam int DEF_FRACTION_DIGITS = 5;

	// quotient bits of the degree division and total latency of the coordinate unit
	localparam int COORD_QBITS = 8;
	localparam int COORD_LAT = COORD_QBITS + 4;

	localparam logic [39:0] ACC_MAX = '1;
	localparam logic [30:0] SAT_MAG = 31'h7FFF_FFFF;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_W = 8'h57;

	localparam logic [3:0] FLD_TIME = 4'd1;
	localparam logic [3:0] FLD_LAT = 4'd2;
	localparam logic [3:0] FLD_NS = 4'd3;
	localparam logic [3:0] FLD_LON = 4'd4;
	localparam logic [3:0] FLD_EW = 4'd5;
	localparam logic [3:0] FLD_QUAL = 4'd6;
	localparam logic [3:0] FLD_SATS = 4'd7;
	localparam logic [3:0] FLD_HDOP = 4'd8;
	localparam logic [3:0] FLD_ALT = 4'd9;
	localparam logic [3:0] FLD_AUNIT = 4'd10;
	localparam logic [3:0] FLD_GEOID = 4'd11;
	localparam logic [3:0] FLD_GUNIT = 4'd12;
	localparam logic [3:0] FLD_LAST = FLD_GUNIT;

	localparam logic [3:0] MIN_FIELDS = 4'd10;
	localparam logic [3:0] GEO_FIELDS = 4'd12;

	typedef enum logic [2:0] {
		PH_INT  = 3'b001,
		PH_FRAC = 3'b010,
		PH_STOP = 3'b100
	} ngga_phase_t;

	typedef struct packed {
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [7:0]  quality_char;
		logic [15:0] satellites_text;
		logic [31:0] hdop_text;
		logic [47:0] altitude_text;
		logic [7:0]  alt_unit_char;
		logic [47:0] geoid_text;
		logic [7:0]  geoid_unit;
	} ngga_fix_t;

	function automatic longint unsigned ngga_pow10(input int n);
		longint unsigned r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	// acc * 10 + d, saturating at the top of the 40-bit range
	function automatic logic [39:0] ngga_mac10(input logic [39:0] a, input logic [3:0] d);
		logic [43:0] r;
		r = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {40'd0, d};
		return (r > {4'd0, ACC_MAX}) ? ACC_MAX : r[39:0];
	endfunction

	function automatic logic [7:0] ngga_hdr_char(input logic [2:0] pos);
		case (pos)
			3'd0: return CH_DOLLAR;
			3'd1: return 8'h47;
			3'd2: return 8'h50;
			3'd3: return 8'h47;
			3'd4: return 8'h47;
			3'd5: return 8'h41;
			3'd6: return CH_COMMA;
			default: return CH_NUL;
		endcase
	endfunction

	function automatic logic [3:0] ngga_fld_max(input logic [3:0] f);
		case (f)
			FLD_TIME: return 4'd10;
			FLD_LAT: return 4'd10;
			FLD_NS: return 4'd1;
			FLD_LON: return 4'd11;
			FLD_EW: return 4'd1;
			FLD_QUAL: return 4'd1;
			FLD_SATS: return 4'd2;
			FLD_HDOP: return 4'd4;
			FLD_ALT: return 4'd6;
			FLD_AUNIT: return 4'd1;
			FLD_GEOID: return 4'd6;
			FLD_GUNIT: return 4'd1;
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic ngga_fld_char(input logic [3:0] f);
		return (f == FLD_NS) || (f == FLD_EW) || (f == FLD_QUAL);
	endfunction

	function automatic logic [6:0] ngga_dd(input logic [3:0] t, input logic [3:0] u);
		return {t, 3'b000} + {2'b00, t, 1'b0} + {3'b000, u};
	endfunction

endpackage

### hdl/nmea_gga_sentence_parser_core.sv
// One received byte is taken per clock with no gaps needed, while byte_stall is low. A byte
// is registered, then parsed from that register; a sentence that closes with a valid header
// and at least ten matched fields launches one fix into a 12-stage coordinate pipeline
// (8 restoring division steps by 100 * 10^FRACTION_DIGITS, two multiplies, a divide-by-60
// correction and a saturate/sign stage). The fix waits in an output register; byte_stall
// rises only when a byte is pending, that register is held by fix_stall and a further fix
// has reached the end of the pipeline.
module nmea_gga_sentence_parser_core import ngga_pkg::*; #(
	parameter int MAX_SENTENCE_BYTES = DEF_MAX_SENTENCE_BYTES,
	parameter int FRACTION_DIGITS = DEF_FRACTION_DIGITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         rx_byte,
	output logic               fix_valid,
	input  logic               fix_stall,
	output logic [6:0]         hours,
	output logic [6:0]         minutes,
	output logic [6:0]         seconds,
	output logic signed [31:0] latitude,
	output logic signed [31:0] longitude,
	output logic [7:0]         quality_char,
	output logic [15:0]        satellites_text,
	output logic [31:0]        hdop_text,
	output logic [47:0]        altitude_text,
	output logic [7:0]         alt_unit_char,
	output logic [47:0]        geoid_text,
	output logic [7:0]         geoid_unit
);

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        pipe_adv;
	logic        fin_valid;
	ngga_fix_t   fin_fix;
	logic [39:0] lat_value, lon_value;
	logic        lat_neg, lon_neg;
	logic signed [31:0] lat_coord, lon_coord;

	logic        dly_valid_q [COORD_LAT];
	ngga_fix_t   dly_fix_q [COORD_LAT];
	logic        out_valid_q;
	ngga_fix_t   out_fix_q;
	logic signed [31:0] out_lat_q, out_lon_q;

	// whole pipeline freezes only when a finished fix cannot move into the held output
	assign pipe_adv = !(dly_valid_q[COORD_LAT-1] && out_valid_q && fix_stall);
	assign byte_stall = valid_s1 && !pipe_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	ngga_parser #(
		.MAX_SENTENCE_BYTES(MAX_SENTENCE_BYTES),
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.en(valid_s1 && pipe_adv),
		.rx_byte(rx_byte_s1),
		.fin_valid(fin_valid),
		.fin_fix(fin_fix),
		.lat_value(lat_value),
		.lat_neg(lat_neg),
		.lon_value(lon_value),
		.lon_neg(lon_neg)
	);

	ngga_coord #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_lat (
		.clk(clk),
		.en(pipe_adv),
		.value(lat_value),
		.neg(lat_neg),
		.coord(lat_coord)
	);

	ngga_coord #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_lon (
		.clk(clk),
		.en(pipe_adv),
		.value(lon_value),
		.neg(lon_neg),
		.coord(lon_coord)
	);

	// text fields ride alongside the coordinate units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COORD_LAT; i++) begin
				dly_valid_q[i] <= 1'b0;
			end
		end else if (pipe_adv) begin
			dly_valid_q[0] <= fin_valid;
			for (int i = 1; i < COORD_LAT; i++) begin
				dly_valid_q[i] <= dly_valid_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_adv) begin
			dly_fix_q[0] <= fin_fix;
			for (int i = 1; i < COORD_LAT; i++) begin
				dly_fix_q[i] <= dly_fix_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pipe_adv && dly_valid_q[COORD_LAT-1]) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !fix_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_adv && dly_valid_q[COORD_LAT-1]) begin
			out_fix_q <= dly_fix_q[COORD_LAT-1];
			out_lat_q <= lat_coord;
			out_lon_q <= lon_coord;
		end
	end

	assign fix_valid       = out_valid_q;
	assign hours           = out_fix_q.hours;
	assign minutes         = out_fix_q.minutes;
	assign seconds         = out_fix_q.seconds;
	assign latitude        = out_lat_q;
	assign longitude       = out_lon_q;
	assign quality_char    = out_fix_q.quality_char;
	assign satellites_text = out_fix_q.satellites_text;
	assign hdop_text       = out_fix_q.hdop_text;
	assign altitude_text   = out_fix_q.altitude_text;
	assign alt_unit_char   = out_fix_q.alt_unit_char;
	assign geoid_text      = out_fix_q.geoid_text;
	assign geoid_unit      = out_fix_q.geoid_unit;

	// the byte side only backs up behind a held fix
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (fix_valid && fix_stall))
		else $error("byte side stalled without a held fix");

	// a new fix only appears from the end of the coordinate pipeline
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fix_valid) |-> $past(dly_valid_q[COORD_LAT-1]))
		else $error("fix request raised with no finished fix");

	// a pending byte is held, not dropped, while the pipeline is frozen
	a_fin_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !pipe_adv) |=> (valid_s1 && $stable(rx_byte_s1)))
		else $error("pending byte lost while pipeline frozen");

endmodule

### hdl/ngga_coord.sv
// ddmm.m count scaled by 10^FRACTION_DIGITS to signed 1e-7 degrees, pipeline advancing on en
module ngga_coord import ngga_pkg::*; #(
	parameter int FRACTION_DIGITS = DEF_FRACTION_DIGITS
) (
	input  logic               clk,
	input  logic               en,
	input  logic [39:0]        value,
	input  logic               neg,
	output logic signed [31:0] coord
);

	localparam longint unsigned P10 = ngga_pow10(FRACTION_DIGITS);
	localparam longint unsigned UNIT = 100 * P10;
	localparam logic [39:0] SAT_THR = 40'(215 * UNIT);
	localparam logic [19:0] CMUL = 20'(ngga_pow10(7 - FRACTION_DIGITS));
	localparam logic [23:0] DMUL = 24'd10000000;
	// floor(2^36 / 60)
	localparam logic [30:0] RECIP = 31'd1145324612;

	logic [39:0]            rem_q [COORD_QBITS];
	logic [COORD_QBITS-1:0] quo_q [COORD_QBITS];
	logic                   sat_q [COORD_QBITS];
	logic                   neg_q [COORD_QBITS];

	for (genvar j = 0; j < COORD_QBITS; j++) begin : g_div
		localparam logic [39:0] DIVB = 40'(UNIT << (COORD_QBITS - 1 - j));
		localparam logic [COORD_QBITS-1:0] QBIT = COORD_QBITS'(1 << (COORD_QBITS - 1 - j));
		logic [39:0]            rem_in;
		logic [COORD_QBITS-1:0] quo_in;
		logic                   sat_in;
		logic                   neg_in;

		if (j == 0) begin : g_first
			assign rem_in = value;
			assign quo_in = '0;
			assign sat_in = value >= SAT_THR;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign quo_in = quo_q[j-1];
			assign sat_in = sat_q[j-1];
			assign neg_in = neg_q[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= DIVB) begin
					rem_q[j] <= rem_in - DIVB;
					quo_q[j] <= quo_in | QBIT;
				end else begin
					rem_q[j] <= rem_in;
					quo_q[j] <= quo_in;
				end
				sat_q[j] <= sat_in;
				neg_q[j] <= neg_in;
			end
		end
	end

	logic [49:0] xprod;
	logic [31:0] dprod;
	logic [29:0] x1_q, x2_q;
	logic [31:0] d1_q, d2_q, d3_q;
	logic        sat1_q, sat2_q, sat3_q;
	logic        neg1_q, neg2_q, neg3_q;
	logic [60:0] p_q;
	logic [24:0] q0;
	logic [30:0] r0;
	logic [24:0] t_q;
	logic [32:0] mag;
	logic [31:0] mag_sat;
	logic signed [31:0] coord_q;

	assign xprod = rem_q[COORD_QBITS-1][29:0] * CMUL;
	assign dprod = quo_q[COORD_QBITS-1] * DMUL;

	// minutes part: x / 60 by reciprocal, then one correction step
	assign q0 = p_q[60:36];
	assign r0 = {1'b0, x2_q} - ({q0, 6'b000000} - {4'b0000, q0, 2'b00});
	assign mag = {1'b0, d3_q} + {8'd0, t_q};
	assign mag_sat = (sat3_q || mag > {2'b00, SAT_MAG}) ? {1'b0, SAT_MAG} : mag[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			x1_q   <= xprod[29:0];
			d1_q   <= dprod;
			sat1_q <= sat_q[COORD_QBITS-1];
			neg1_q <= neg_q[COORD_QBITS-1];

			p_q    <= x1_q * RECIP;
			x2_q   <= x1_q;
			d2_q   <= d1_q;
			sat2_q <= sat1_q;
			neg2_q <= neg1_q;

			t_q    <= (r0 >= 31'd60) ? q0 + 25'd1 : q0;
			d3_q   <= d2_q;
			sat3_q <= sat2_q;
			neg3_q <= neg2_q;

			coord_q <= neg3_q ? -signed'(mag_sat) : signed'(mag_sat);
		end
	end

	assign coord = coord_q;

endmodule

### hdl/ngga_parser.sv
// per-byte sentence state: header check, field matching and field capture
module ngga_parser import ngga_pkg::*; #(
	parameter int MAX_SENTENCE_BYTES = DEF_MAX_SENTENCE_BYTES,
	parameter int FRACTION_DIGITS = DEF_FRACTION_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  rx_byte,
	output logic        fin_valid,
	output ngga_fix_t   fin_fix,
	output logic [39:0] lat_value,
	output logic        lat_neg,
	output logic [39:0] lon_value,
	output logic        lon_neg
);

	localparam logic [6:0] MAXB = 7'(MAX_SENTENCE_BYTES);
	localparam logic [2:0] FD = 3'(FRACTION_DIGITS);

	logic        in_sent_q, in_sent_n;
	logic [6:0]  len_q, len_n;
	logic        hdr_ok_q, hdr_ok_n;
	logic [3:0]  fidx_q, fidx_n;
	logic [3:0]  flen_q, flen_n;
	logic        failed_q, failed_n;
	logic [3:0]  matched_q, matched_n;
	logic [23:0] time_q, time_n;
	logic [39:0] lat_q, lat_n;
	logic [39:0] lon_q, lon_n;
	logic [2:0]  frac_q, frac_n;
	ngga_phase_t phase_q, phase_n;
	logic [2:0]  lat_scl_q, lat_scl_n;
	logic [2:0]  lon_scl_q, lon_scl_n;
	logic [7:0]  ns_q, ns_n;
	logic [7:0]  ew_q, ew_n;
	logic [7:0]  qual_q, qual_n;
	logic [15:0] sats_q, sats_n;
	logic [31:0] hdop_q, hdop_n;
	logic [47:0] alt_q, alt_n;
	logic [7:0]  aunit_q, aunit_n;
	logic [47:0] geoid_q, geoid_n;
	logic [7:0]  gunit_q, gunit_n;

	logic        digit;
	logic        fin;
	logic        do_adv;
	logic        do_store;
	logic [39:0] acc_sel;
	logic [39:0] nc_acc;
	logic [2:0]  nc_frac;
	ngga_phase_t nc_phase;
	logic        geo;

	assign digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);

	always_comb begin
		in_sent_n = in_sent_q;
		len_n     = len_q;
		hdr_ok_n  = hdr_ok_q;
		fidx_n    = fidx_q;
		flen_n    = flen_q;
		failed_n  = failed_q;
		matched_n = matched_q;
		time_n    = time_q;
		lat_n     = lat_q;
		lon_n     = lon_q;
		frac_n    = frac_q;
		phase_n   = phase_q;
		lat_scl_n = lat_scl_q;
		lon_scl_n = lon_scl_q;
		ns_n      = ns_q;
		ew_n      = ew_q;
		qual_n    = qual_q;
		sats_n    = sats_q;
		hdop_n    = hdop_q;
		alt_n     = alt_q;
		aunit_n   = aunit_q;
		geoid_n   = geoid_q;
		gunit_n   = gunit_q;
		fin       = 1'b0;
		do_adv    = 1'b0;
		do_store  = 1'b0;

		// missing fraction digits are padded one per clock after the field closes
		if (lat_scl_q != 3'd0) begin
			lat_n     = ngga_mac10(lat_q, 4'd0);
			lat_scl_n = lat_scl_q - 3'd1;
		end
		if (lon_scl_q != 3'd0) begin
			lon_n     = ngga_mac10(lon_q, 4'd0);
			lon_scl_n = lon_scl_q - 3'd1;
		end

		acc_sel  = (fidx_q == FLD_LON) ? lon_q : lat_q;
		nc_acc   = acc_sel;
		nc_frac  = frac_q;
		nc_phase = phase_q;
		case (phase_q)
			PH_INT: begin
				if (digit) begin
					nc_acc = ngga_mac10(acc_sel, rx_byte[3:0]);
				end else begin
					nc_phase = (rx_byte == CH_DOT) ? PH_FRAC : PH_STOP;
				end
			end
			PH_FRAC: begin
				if (digit) begin
					if (frac_q < FD) begin
						nc_acc  = ngga_mac10(acc_sel, rx_byte[3:0]);
						nc_frac = frac_q + 3'd1;
					end
				end else begin
					nc_phase = PH_STOP;
				end
			end
			PH_STOP: begin
			end
			default: begin
			end
		endcase

		if (en) begin
			if (!in_sent_q) begin
				if (rx_byte == CH_DOLLAR) begin
					in_sent_n = 1'b1;
					len_n     = 7'd1;
					hdr_ok_n  = 1'b0;
					fidx_n    = '0;
					flen_n    = '0;
					failed_n  = 1'b0;
					matched_n = '0;
					time_n    = '0;
					lat_n     = '0;
					lon_n     = '0;
					frac_n    = '0;
					phase_n   = PH_INT;
					lat_scl_n = '0;
					lon_scl_n = '0;
					ns_n      = '0;
					ew_n      = '0;
					qual_n    = '0;
					sats_n    = '0;
					hdop_n    = '0;
					alt_n     = '0;
					aunit_n   = '0;
					geoid_n   = '0;
					gunit_n   = '0;
				end
			end else if (rx_byte == CH_NL) begin
				fin       = 1'b1;
				in_sent_n = 1'b0;
			end else begin
				len_n = len_q + 7'd1;
				if (!failed_q && fidx_q <= FLD_LAST) begin
					if (rx_byte == CH_NUL) begin
						failed_n = 1'b1;
					end else if (!hdr_ok_q) begin
						if (len_q >= 7'd7 || rx_byte != ngga_hdr_char(len_q[2:0])) begin
							failed_n = 1'b1;
						end else if (len_q == 7'd6) begin
							hdr_ok_n = 1'b1;
							fidx_n   = FLD_TIME;
							flen_n   = '0;
						end
					end else begin
						if (flen_q >= ngga_fld_max(fidx_q)) begin
							if (rx_byte == CH_COMMA) begin
								do_adv = 1'b1;
							end else begin
								failed_n = 1'b1;
							end
						end else if (ngga_fld_char(fidx_q)) begin
							do_store  = 1'b1;
							matched_n = matched_q + 4'd1;
							flen_n    = 4'd1;
						end else if (rx_byte == CH_COMMA) begin
							if (flen_q == 4'd0) begin
								failed_n = 1'b1;
							end else begin
								do_adv = 1'b1;
							end
						end else begin
							if (flen_q == 4'd0) begin
								matched_n = matched_q + 4'd1;
							end
							do_store = 1'b1;
							flen_n   = flen_q + 4'd1;
						end

						if (do_store) begin
							case (fidx_q)
								FLD_TIME: begin
									if (flen_q < 4'd6 && digit) begin
										time_n[{flen_q[2:0], 2'b00} +: 4] = rx_byte[3:0];
									end
								end
								FLD_LAT: begin
									lat_n   = nc_acc;
									frac_n  = nc_frac;
									phase_n = nc_phase;
								end
								FLD_NS: ns_n = rx_byte;
								FLD_LON: begin
									lon_n   = nc_acc;
									frac_n  = nc_frac;
									phase_n = nc_phase;
								end
								FLD_EW: ew_n = rx_byte;
								FLD_QUAL: qual_n = rx_byte;
								FLD_SATS: sats_n[{flen_q[0], 3'b000} +: 8] = rx_byte;
								FLD_HDOP: hdop_n[{flen_q[1:0], 3'b000} +: 8] = rx_byte;
								FLD_ALT: alt_n[{flen_q[2:0], 3'b000} +: 8] = rx_byte;
								FLD_AUNIT: aunit_n = rx_byte;
								FLD_GEOID: geoid_n[{flen_q[2:0], 3'b000} +: 8] = rx_byte;
								FLD_GUNIT: gunit_n = rx_byte;
								default: begin
								end
							endcase
						end

						if (do_adv) begin
							if (fidx_q == FLD_LAT) begin
								lat_scl_n = FD - frac_q;
							end
							if (fidx_q == FLD_LON) begin
								lon_scl_n = FD - frac_q;
							end
							fidx_n  = fidx_q + 4'd1;
							flen_n  = '0;
							frac_n  = '0;
							phase_n = PH_INT;
						end
					end
				end
				if (len_n >= MAXB) begin
					fin       = 1'b1;
					in_sent_n = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0;
			len_q     <= '0;
			hdr_ok_q  <= 1'b0;
			fidx_q    <= '0;
			flen_q    <= '0;
			failed_q  <= 1'b0;
			matched_q <= '0;
			time_q    <= '0;
			lat_q     <= '0;
			lon_q     <= '0;
			frac_q    <= '0;
			phase_q   <= PH_INT;
			lat_scl_q <= '0;
			lon_scl_q <= '0;
			ns_q      <= '0;
			ew_q      <= '0;
			qual_q    <= '0;
			sats_q    <= '0;
			hdop_q    <= '0;
			alt_q     <= '0;
			aunit_q   <= '0;
			geoid_q   <= '0;
			gunit_q   <= '0;
		end else begin
			in_sent_q <= in_sent_n;
			len_q     <= len_n;
			hdr_ok_q  <= hdr_ok_n;
			fidx_q    <= fidx_n;
			flen_q    <= flen_n;
			failed_q  <= failed_n;
			matched_q <= matched_n;
			time_q    <= time_n;
			lat_q     <= lat_n;
			lon_q     <= lon_n;
			frac_q    <= frac_n;
			phase_q   <= phase_n;
			lat_scl_q <= lat_scl_n;
			lon_scl_q <= lon_scl_n;
			ns_q      <= ns_n;
			ew_q      <= ew_n;
			qual_q    <= qual_n;
			sats_q    <= sats_n;
			hdop_q    <= hdop_n;
			alt_q     <= alt_n;
			aunit_q   <= aunit_n;
			geoid_q   <= geoid_n;
			gunit_q   <= gunit_n;
		end
	end

	assign geo = matched_n >= GEO_FIELDS;
	assign fin_valid = fin && hdr_ok_n && (matched_n >= MIN_FIELDS);

	always_comb begin
		fin_fix.hours           = ngga_dd(time_n[3:0], time_n[7:4]);
		fin_fix.minutes         = ngga_dd(time_n[11:8], time_n[15:12]);
		fin_fix.seconds         = ngga_dd(time_n[19:16], time_n[23:20]);
		fin_fix.quality_char    = qual_n;
		fin_fix.satellites_text = sats_n;
		fin_fix.hdop_text       = hdop_n;
		fin_fix.altitude_text   = alt_n;
		fin_fix.alt_unit_char   = aunit_n;
		fin_fix.geoid_text      = geo ? geoid_n : '0;
		fin_fix.geoid_unit      = geo ? gunit_n : '0;
	end

	assign lat_value = lat_n;
	assign lon_value = lon_n;
	assign lat_neg = (ns_n == CH_S) || (ns_n == CH_W);
	assign lon_neg = (ew_n == CH_S) || (ew_n == CH_W);

endmodule

### dv/testbench.sv
// self-checking testbench of the gga sentence parser core: byte stream in, checked fixes out
`timescale 1ns / 100ps

module testbench;
	import ngga_pkg::*;

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	logic [7:0] rx_byte;
	logic fix_valid;
	logic fix_stall;
	logic [6:0] hours, minutes, seconds;
	logic signed [31:0] latitude, longitude;
	logic [7:0] quality_char;
	logic [15:0] satellites_text;
	logic [31:0] hdop_text;
	logic [47:0] altitude_text;
	logic [7:0] alt_unit_char;
	logic [47:0] geoid_text;
	logic [7:0] geoid_unit;

	typedef struct packed {
		logic [6:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
		logic [31:0] latitude;
		logic [31:0] longitude;
		ngga_fix_t fix;
	} gga_fix_t;

	gga_fix_t pending_fixes[$];
	int errors;
	int fix_count;
	longint cycle_count;
	bit stall_on;

	// parser state mirror
	bit in_sent;
	int sent_len;
	bit hdr_ok;
	int fld_idx;
	int fld_len;
	bit failed;
	int n_matched;
	logic [23:0] t_digits;
	logic [39:0] lat_acc, lon_acc;
	int frac_cnt;
	int num_ph;
	logic [7:0] ns_char, ew_char, qual_char, aunit_char, gunit_char;
	logic [15:0] sats_t;
	logic [31:0] hdop_t;
	logic [47:0] alt_t, geoid_t;

	nmea_gga_sentence_parser_core i_dut (
		.clk(clk), .arst_n(arst_n), .byte_valid(byte_valid), .byte_stall(byte_stall),
		.rx_byte(rx_byte), .fix_valid(fix_valid), .fix_stall(fix_stall),
		.hours(hours), .minutes(minutes), .seconds(seconds), .latitude(latitude),
		.longitude(longitude), .quality_char(quality_char),
		.satellites_text(satellites_text),
		.hdop_text(hdop_text), .altitude_text(altitude_text), .alt_unit_char(alt_unit_char),
		.geoid_text(geoid_text), .geoid_unit(geoid_unit)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [39:0] acc_digit(logic [39:0] a, int d);
		logic [43:0] r;
		r = 44'(a) * 10 + d;
		return (r > 44'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : r[39:0];
	endfunction

	function automatic logic [31:0] degrees_e7(logic [39:0] acc, bit neg);
		longint unsigned unit, d, m, mag;
		unit = 64'd10_000_000;
		d = acc / unit;
		m = acc % unit;
		mag = d * 64'd10_000_000 + (m * 64'd10_000_000) / 64'd6_000_000;
		if (mag > 64'd2147483647)
			mag = 64'd2147483647;
		return neg ? 32'(-mag) : 32'(mag);
	endfunction

	function automatic int field_limit(int f);
		case (f)
			FLD_TIME, FLD_LAT: return 10;
			FLD_LON: return 11;
			FLD_SATS: return 2;
			FLD_HDOP: return 4;
			FLD_ALT, FLD_GEOID: return 6;
			default: return 1;
		endcase
	endfunction

	task automatic take_number_char(ref logic [39:0] acc, input logic [7:0] b);
		bit dig;
		dig = b >= "0" && b <= "9";
		if (num_ph == 0) begin
			if (dig)
				acc = acc_digit(acc, b - "0");
			else
				num_ph = (b == CH_DOT) ? 1 : 2;
		end else if (num_ph == 1) begin
			if (!dig)
				num_ph = 2;
			else if (frac_cnt < DEF_FRACTION_DIGITS) begin
				acc = acc_digit(acc, b - "0");
				frac_cnt++;
			end
		end
	endtask

	task automatic store_field_char(int p, logic [7:0] b);
		case (fld_idx)
			FLD_TIME: if (p < 6 && b >= "0" && b <= "9") t_digits[4*p +: 4] = 4'(b - "0");
			FLD_LAT: take_number_char(lat_acc, b);
			FLD_NS: ns_char = b;
			FLD_LON: take_number_char(lon_acc, b);
			FLD_EW: ew_char = b;
			FLD_QUAL: qual_char = b;
			FLD_SATS: if (p < 2) sats_t[8*p +: 8] = b;
			FLD_HDOP: if (p < 4) hdop_t[8*p +: 8] = b;
			FLD_ALT: if (p < 6) alt_t[8*p +: 8] = b;
			FLD_AUNIT: aunit_char = b;
			FLD_GEOID: if (p < 6) geoid_t[8*p +: 8] = b;
			FLD_GUNIT: gunit_char = b;
			default: ;
		endcase
	endtask

	task automatic next_field();
		if (fld_idx == FLD_LAT)
			for (int i = frac_cnt; i < DEF_FRACTION_DIGITS; i++) lat_acc = acc_digit(lat_acc, 0);
		else if (fld_idx == FLD_LON)
			for (int i = frac_cnt; i < DEF_FRACTION_DIGITS; i++) lon_acc = acc_digit(lon_acc, 0);
		fld_idx++;
		fld_len = 0;
		frac_cnt = 0;
		num_ph = 0;
	endtask

	task automatic close_sentence();
		gga_fix_t e;
		bit geo;
		in_sent = 0;
		if (!hdr_ok || n_matched < 10)
			return;
		geo = n_matched >= 12;
		e = '0;
		e.hours = 7'(t_digits[3:0] * 10 + t_digits[7:4]);
		e.minutes = 7'(t_digits[11:8] * 10 + t_digits[15:12]);
		e.seconds = 7'(t_digits[19:16] * 10 + t_digits[23:20]);
		e.latitude = degrees_e7(lat_acc, ns_char == CH_S || ns_char == CH_W);
		e.longitude = degrees_e7(lon_acc, ew_char == CH_S || ew_char == CH_W);
		e.fix.quality_char = qual_char;
		e.fix.satellites_text = sats_t;
		e.fix.hdop_text = hdop_t;
		e.fix.altitude_text = alt_t;
		e.fix.alt_unit_char = aunit_char;
		e.fix.geoid_text = geo ? geoid_t : '0;
		e.fix.geoid_unit = geo ? gunit_char : '0;
		pending_fixes.push_back(e);
	endtask

	task automatic predict_byte(logic [7:0] b);
		int lim;
		if (!in_sent) begin
			if (b == CH_DOLLAR) begin
				in_sent = 1; sent_len = 1; hdr_ok = 0; fld_idx = 0; fld_len = 0;
				failed = 0; n_matched = 0; t_digits = '0; lat_acc = '0; lon_acc = '0;
				frac_cnt = 0; num_ph = 0; ns_char = 0; ew_char = 0; qual_char = 0;
				aunit_char = 0; gunit_char = 0; sats_t = '0; hdop_t = '0; alt_t = '0;
				geoid_t = '0;
			end
			return;
		end
		if (b == CH_NL) begin
			close_sentence();
			return;
		end
		sent_len++;
		if (!failed && fld_idx <= FLD_LAST) begin
			if (b == CH_NUL)
				failed = 1;
			else if (!hdr_ok) begin
				if (sent_len - 1 >= 7 || b != ngga_hdr_char(3'(sent_len - 1)))
					failed = 1;
				else if (sent_len - 1 == 6) begin
					hdr_ok = 1; fld_idx = FLD_TIME; fld_len = 0;
				end
			end else begin
				lim = field_limit(fld_idx);
				if (fld_len >= lim) begin
					if (b == CH_COMMA) next_field();
					else failed = 1;
				end else if (ngga_fld_char(4'(fld_idx))) begin
					store_field_char(0, b);
					n_matched++;
					fld_len = 1;
				end else if (b == CH_COMMA) begin
					if (fld_len == 0) failed = 1;
					else next_field();
				end else begin
					if (fld_len == 0) n_matched++;
					store_field_char(fld_len, b);
					fld_len++;
				end
			end
		end
		if (sent_len >= DEF_MAX_SENTENCE_BYTES)
			close_sentence();
	endtask

	// idle gap before a request; valid drops only while idling
	task automatic gap(int pct);
		if ($urandom_range(99) < pct) begin
			byte_valid <= 1'b0;
			repeat (($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1))
				@(posedge clk);
		end
	endtask

	// one byte request, held until accepted
	task automatic send_byte(logic [7:0] b, int gap_pct = 20);
		gap(gap_pct);
		byte_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (byte_stall);
		predict_byte(b);
	endtask

	task automatic send_text(string s, int gap_pct = 20);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], gap_pct);
	endtask

	function automatic string rand_digits(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
		return s;
	endfunction

	function automatic string rand_text(int n);
		string s;
		byte c;
		s = "";
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: c = "0" + $urandom_range(9);
				1: c = "A" + $urandom_range(25);
				2: c = ".";
				default: c = $urandom_range(255, 1);
			endcase
			if (c == CH_COMMA || c == CH_NL) c = "M";
			s = {s, string'(c)};
		end
		return s;
	endfunction

	function automatic string rand_coord(int degs);
		string s;
		s = {rand_digits(degs + 2), ".", rand_digits($urandom_range(8))};
		if ($urandom_range(15) == 0) s = rand_digits($urandom_range(1, 11));
		if ($urandom_range(15) == 0) s = {rand_digits(3), "-", rand_digits(2)};
		if ($urandom_range(15) == 0) s = "9999999999";
		return s.substr(0, ((s.len() > 10 + degs - 2) ? 10 + degs - 2 : s.len()) - 1);
	endfunction

	function automatic string rand_gga();
		string s;
		string hem[4] = '{"N", "S", "E", "W"};
		s = {"$GPGGA,", rand_digits($urandom_range(1, 10)), ",", rand_coord(2), ",",
			hem[$urandom_range(3)], ",", rand_coord(3), ",", hem[$urandom_range(3)], ",",
			rand_digits(1), ",", rand_text($urandom_range(1, 2)), ",",
			rand_text($urandom_range(1, 4)), ",", rand_text($urandom_range(1, 6)), ",M"};
		case ($urandom_range(3))
			0: ;
			1: s = {s, ",", rand_text($urandom_range(1, 6)), ",M"};
			2: s = {s, ",", rand_text($urandom_range(1, 6)), ",M,", rand_text(3)};
			default: s = {s, ","};
		endcase
		return s;
	endfunction

	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (pending_fixes.size() != 0) @(posedge clk);
		repeat (COORD_LAT + 6) @(posedge clk);
	endtask

	task automatic test_directed();
		send_text("junk$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,\n");
		send_text("$GPGGA,235959.99,9000.00000,S,18000.00000,W,2,12,99.9,-123.4,M\n");
		send_text("$GPGGA,ab12:9,4807.03812345,N,01131.5e3,W,0,,1,2,M\n");
		send_text("$GPGGA,1,9999999999,S,99999999999,E,,0,1,2,M,x,F\n");
		send_text("$GPGGA,1,2,N,3,E,1,0,1,2,,\n");
		// zero byte inside the geoid field
		send_text("$GPGGA,1,2,N,3,E,1,2,3,4,M,5");
		send_byte(CH_NUL);
		send_text(",M\n");
		send_text("$GPGGA,1,2,N,3,E,1,2,3,45678901,M\n");
		send_text("$GPGGA,1,2,N,3,E,1,2,3,4,M,5,M,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20,2");
		send_text("$GPGGA,1,2,,,,,1,2,3,$,\n$GPRMC,1\n");
		send_text({"$GPGGA,", {8{"\377"}}, ",2,N,3,E,\001,2,3,4,M\n"});
	endtask

	task automatic test_random();
		string s;
		int n;
		n = 0;
		while (n < 1000) begin
			s = rand_gga();
			if ($urandom_range(9) == 0) s[$urandom_range(s.len() - 1)] = $urandom_range(255);
			if ($urandom_range(19) == 0) s = {s, rand_text(30)};
			if ($urandom_range(14) == 0) s = rand_text($urandom_range(1, 20));
			s = {s, "\n"};
			send_text(s, $urandom_range(3) == 0 ? 0 : 15);
			n += s.len();
			if ($urandom_range(9) == 0) send_byte($urandom_range(255));
		end
	endtask

	task automatic test_back_to_back();
		stall_on = 0;
		for (int i = 0; i < 4; i++) send_text({rand_gga(), "\n"}, 0);
		stall_on = 1;
		for (int i = 0; i < 4; i++) send_text({rand_gga(), "\n"}, 0);
	endtask

	// result checker
	always @(posedge clk) begin
		gga_fix_t e;
		cycle_count <= cycle_count + 1;
		if (arst_n && fix_valid && !fix_stall) begin
			fix_count++;
			if (pending_fixes.size() == 0) begin
				errors++;
				$display("%0t: unexpected fix, latitude %0d", $time, latitude);
			end else begin
				e = pending_fixes.pop_front();
				if ({hours, minutes, seconds} !== {e.hours, e.minutes, e.seconds}) begin
					errors++;
					$display("%0t: time exp %0d:%0d:%0d got %0d:%0d:%0d", $time,
						e.hours, e.minutes, e.seconds, hours, minutes, seconds);
				end
				if (latitude !== e.latitude || longitude !== e.longitude) begin
					errors++;
					$display("%0t: position exp %0d %0d got %0d %0d", $time,
						$signed(e.latitude), $signed(e.longitude), latitude, longitude);
				end
				if ({quality_char, satellites_text, hdop_text, altitude_text, alt_unit_char,
						geoid_text, geoid_unit} !== {e.fix.quality_char, e.fix.satellites_text,
						e.fix.hdop_text, e.fix.altitude_text, e.fix.alt_unit_char,
						e.fix.geoid_text, e.fix.geoid_unit}) begin
					errors++;
					$display("%0t: text fields exp %h got %h", $time,
						{e.fix.quality_char, e.fix.satellites_text, e.fix.hdop_text,
						e.fix.altitude_text, e.fix.alt_unit_char, e.fix.geoid_text,
						e.fix.geoid_unit},
						{quality_char, satellites_text, hdop_text, altitude_text, alt_unit_char,
						geoid_text, geoid_unit});
				end
			end
		end
		if (cycle_count > 400000) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver stalls: long runs of no stall mixed with bursts
	always @(posedge clk) begin
		if (!stall_on)
			fix_stall <= 1'b0;
		else if ($urandom_range(99) < 5)
			fix_stall <= 1'b1;
		else if ($urandom_range(99) < 30)
			fix_stall <= 1'b0;
	end

	initial begin
		errors = 0;
		fix_count = 0;
		cycle_count = 0;
		stall_on = 1;
		in_sent = 0;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		rx_byte = 8'h00;
		fix_stall = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_back_to_back();
		wait_drained();
		test_random();
		wait_drained();
		if (errors == 0 && pending_fixes.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
